// File: sv/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg
// shared types and constants of the ipv4 header check and classify block
// ----------------------------------------------------------------------------
package ihc_pkg;

  // header layout
  localparam int unsigned HdrWords = 10;
  localparam logic [3:0] WcMax     = 4'd15;
  localparam logic [3:0] PosVerIhl = 4'd0;
  localparam logic [3:0] PosTotLen = 4'd1;
  localparam logic [3:0] PosProto  = 4'd4;
  localparam logic [3:0] PosCsum   = 4'd5;
  localparam logic [3:0] PosDstHi  = 4'd8;
  localparam logic [3:0] PosDstLo  = 4'd9;

  localparam logic [3:0] IpVersion = 4'd4;
  localparam logic [3:0] MinIhl    = 4'd5;
  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  // depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [2:0] {
    VERDICT_BAD_VER = 3'd0,
    VERDICT_BAD_SUM = 3'd1,
    VERDICT_BAD_LEN = 3'd2,
    VERDICT_FORWARD = 3'd3,
    VERDICT_ICMP    = 3'd4,
    VERDICT_UDP     = 3'd5,
    VERDICT_OTHER   = 3'd6
  } verdict_e;

  // one finished header, handed from front to back
  typedef struct packed {
    logic [15:0] run_sum;
    logic [15:0] stored_csum;
    logic [7:0]  version_ihl;
    logic [15:0] total_length;
    logic [7:0]  protocol;
    logic [31:0] dst_addr;
    logic [15:0] frame_length;
  } hdr_rec_t;

  // push side of the queue
  typedef struct packed {
    logic     push;
    hdr_rec_t rec;
  } q_push_t;

endpackage

// File: sv/ipv4_header_check_classify.sv
// ----------------------------------------------------------------------------
// ipv4_header_check_classify
// checks an ipv4 base header word by word and classifies the packet
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------
//   in       | sink      | in_valid_i / in_stall_o | header_word, frame_length,
//            |           |                         | last_word
//   out      | source    | out_valid_o/out_stall_i | verdict
//   cfg      | sink      | cfg_valid_i/cfg_ready_o | own_address (cfg_data_i)
//
// - one header word beat per cycle while the header queue is not full; the front
//   adds each word but the checksum word into a 16-bit ones' complement sum
// - the edge that takes the beat carrying last_word writes its record into the
//   queue; a pop then moves the verdict into the output register, which waits
//   while a held verdict sees an output stall
// - a header queue of QueueDepth entries sits between front and back, so an
//   output stall only holds the input once the queue has filled
// - reset clears the word count, running sum, latched fields, queue and
//   own_address; no clearing pass
//
module ipv4_header_check_classify
  import ihc_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // header word beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] header_word_i,
  input  logic [15:0] frame_length_i,
  input  logic        last_word_i,
  // verdict beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  verdict_o,
  // own address register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic        in_accept;
  q_push_t     q_push;
  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;
  hdr_rec_t    q_rec;
  logic [31:0] own_addr_q;

  // the input only waits when the header queue is full
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      own_addr_q <= cfg_data_i;
    end
  end

  // front: per-word sum and field capture, pushes one record per packet
  ihc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .header_word_i  (header_word_i),
    .frame_length_i (frame_length_i),
    .last_word_i    (last_word_i),
    .q_push_o       (q_push)
  );

  // queue of finished headers
  ihc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_push_i    (q_push),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .not_empty_o (q_not_empty),
    .rec_o       (q_rec)
  );

  // back: checks in order version/ihl, checksum, length, then classifies
  ihc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .own_addr_i    (own_addr_q),
    .q_not_empty_i (q_not_empty),
    .rec_i         (q_rec),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .verdict_o     (verdict_o)
  );

endmodule

// File: sv/ihc_front.sv
// ----------------------------------------------------------------------------
// ihc_front
// takes header words, keeps the running sum and the latched fields
// ----------------------------------------------------------------------------
module ihc_front
  import ihc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [15:0] header_word_i,
  input  logic [15:0] frame_length_i,
  input  logic        last_word_i,
  output q_push_t     q_push_o
);

  logic [3:0]  wc_q, wc_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  vihl_q, vihl_d;
  logic [15:0] tlen_q, tlen_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] csum_q, csum_d;
  logic [31:0] dst_q, dst_d;
  logic [16:0] add_full;
  logic [15:0] add_oc;

  // ones' complement add with end-around carry
  assign add_full = {1'b0, sum_q} + {1'b0, header_word_i};
  assign add_oc   = add_full[15:0] + {15'd0, add_full[16]};

  always_comb begin
    wc_d    = wc_q;
    sum_d   = sum_q;
    vihl_d  = vihl_q;
    tlen_d  = tlen_q;
    proto_d = proto_q;
    csum_d  = csum_q;
    dst_d   = dst_q;
    if (wc_q < 4'(HdrWords)) begin
      if (wc_q == PosCsum) begin
        csum_d = header_word_i;
      end else begin
        sum_d = add_oc;
      end
      case (wc_q)
        PosVerIhl: vihl_d        = header_word_i[15:8];
        PosTotLen: tlen_d        = header_word_i;
        PosProto:  proto_d       = header_word_i[7:0];
        PosDstHi:  dst_d[31:16]  = header_word_i;
        PosDstLo:  dst_d[15:0]   = header_word_i;
        default: ;
      endcase
    end
    if (wc_q != WcMax) begin
      wc_d = wc_q + 4'd1;
    end
  end

  // the record carries the fields including the last word
  always_comb begin
    q_push_o.push              = accept_i && last_word_i;
    q_push_o.rec.run_sum       = sum_d;
    q_push_o.rec.stored_csum   = csum_d;
    q_push_o.rec.version_ihl   = vihl_d;
    q_push_o.rec.total_length  = tlen_d;
    q_push_o.rec.protocol      = proto_d;
    q_push_o.rec.dst_addr      = dst_d;
    q_push_o.rec.frame_length  = frame_length_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q    <= '0;
      sum_q   <= '0;
      vihl_q  <= '0;
      tlen_q  <= '0;
      proto_q <= '0;
      csum_q  <= '0;
      dst_q   <= '0;
    end else if (accept_i) begin
      if (last_word_i) begin
        wc_q    <= '0;
        sum_q   <= '0;
        vihl_q  <= '0;
        tlen_q  <= '0;
        proto_q <= '0;
        csum_q  <= '0;
        dst_q   <= '0;
      end else begin
        wc_q    <= wc_d;
        sum_q   <= sum_d;
        vihl_q  <= vihl_d;
        tlen_q  <= tlen_d;
        proto_q <= proto_d;
        csum_q  <= csum_d;
        dst_q   <= dst_d;
      end
    end
  end

endmodule

// File: sv/ihc_queue.sv
// ----------------------------------------------------------------------------
// ihc_queue
// short register queue of finished headers between front and back
// ----------------------------------------------------------------------------
module ihc_queue
  import ihc_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_push_t  q_push_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     not_empty_o,
  output hdr_rec_t rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  hdr_rec_t            slot_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o      = (cnt_q == CntFull);
  assign not_empty_o = (cnt_q != '0);
  assign rec_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (q_push_i.push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (q_push_i.push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!q_push_i.push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_push_i.push) begin
      slot_q[wr_ptr_q] <= q_push_i.rec;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push_i.push && full_o && !pop_i))
    else $error("header pushed into full queue");

  a_pop_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !q_push_i.push && not_empty_o) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule

// File: sv/ihc_back.sv
// ----------------------------------------------------------------------------
// ihc_back
// judges one finished header and holds the verdict in the output register
// ----------------------------------------------------------------------------
module ihc_back
  import ihc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] own_addr_i,
  input  logic        q_not_empty_i,
  input  hdr_rec_t    rec_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  verdict_o
);

  logic       vld_q;
  verdict_e   verdict_q, verdict_d;
  logic [3:0] version;
  logic [3:0] ihl;
  logic [5:0] min_len;

  assign version = rec_i.version_ihl[7:4];
  assign ihl     = rec_i.version_ihl[3:0];
  assign min_len = {ihl, 2'b00};

  always_comb begin
    if (ihl < MinIhl || version != IpVersion) begin
      verdict_d = VERDICT_BAD_VER;
    end else if (rec_i.stored_csum != ~rec_i.run_sum) begin
      verdict_d = VERDICT_BAD_SUM;
    end else if (rec_i.frame_length < rec_i.total_length ||
                 rec_i.total_length < {10'd0, min_len}) begin
      verdict_d = VERDICT_BAD_LEN;
    end else if (rec_i.dst_addr != own_addr_i) begin
      verdict_d = VERDICT_FORWARD;
    end else if (rec_i.protocol == ProtoIcmp) begin
      verdict_d = VERDICT_ICMP;
    end else if (rec_i.protocol == ProtoUdp) begin
      verdict_d = VERDICT_UDP;
    end else begin
      verdict_d = VERDICT_OTHER;
    end
  end

  assign pop_o       = q_not_empty_i && (!vld_q || !out_stall_i);
  assign out_valid_o = vld_q;
  assign verdict_o   = verdict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_q <= verdict_d;
    end
  end

endmodule
